// ----- rtl/core/sbf_pkg.sv -----
`default_nettype none
package sbf_pkg;

	localparam int unsigned WINDOW_DEPTH = 8;
	localparam int unsigned NUM_PATTERNS = 6;
	localparam int unsigned MAX_PAT_LEN  = 9;
	localparam int unsigned PAT_BITS     = MAX_PAT_LEN * 8;
	localparam int unsigned RESP_PATTERN = 5;

	localparam logic [15:0] HTTP_PORT_RESET = 16'd80;

	// Patterns are right-justified: the last character sits in bits [7:0], so the
	// character k places back from the newest byte is at bits [8*k +: 8].
	localparam logic [PAT_BITS-1:0] PAT_STR [NUM_PATTERNS] = '{
		PAT_BITS'("GET "),
		PAT_BITS'("HEAD "),
		PAT_BITS'("POST "),
		PAT_BITS'("PUT "),
		PAT_BITS'("OPTION "),
		PAT_BITS'("HTTP/1.1 ")
	};

	localparam int unsigned PAT_LEN [NUM_PATTERNS] = '{4, 5, 5, 4, 7, 9};

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic        first_of_packet;
		logic        last_of_packet;
	} sbf_in_t;

	typedef struct packed {
		logic [6:0] text_byte;
		logic       end_of_packet;
		logic       is_http;
	} sbf_out_t;

	typedef struct packed {
		logic       valid;
		logic       mark;
		logic [7:0] data;
	} cell_t;

	function automatic logic is_text(input logic [7:0] b);
		return ((b >= 8'h09) && (b <= 8'h0D)) || ((b >= 8'h20) && (b <= 8'h7E));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sbf_cell.sv -----
`default_nettype none
module sbf_cell (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    shift,
	input  wire logic                                    kill,
	input  wire logic                                    mark_set,
	input  wire sbf_pkg::cell_t                          load,
	input  wire logic [sbf_pkg::NUM_PATTERNS-1:0][7:0]   pattern_bytes,
	input  wire logic [sbf_pkg::NUM_PATTERNS-1:0]        pattern_used,
	output sbf_pkg::cell_t                               slot,
	output logic [sbf_pkg::NUM_PATTERNS-1:0]             hit
);
	import sbf_pkg::*;

	logic       valid_q;
	logic       mark_q;
	logic [7:0] data_q;
	logic       live;

	// A new packet discards whatever the cell still holds.
	assign live = valid_q & ~kill;

	always_comb begin
		slot.valid = live;
		slot.mark  = live & (mark_q | mark_set);
		slot.data  = data_q;
	end

	// A pattern position that this cell does not cover never blocks a match.
	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			hit[p] = ~pattern_used[p] | (live & (data_q == pattern_bytes[p]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= load.valid;
			mark_q  <= load.mark;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= load.data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/http_signature_byte_filter.sv -----
// HTTP signature byte filter. Packet bytes enter on the item channel, one word per
// cycle while item_stall is low, from the IP header onward; the ports are taken with
// the first byte. Once a request pattern (destination port equal to http_port) or the
// response pattern (source port equal to http_port) has been seen, every printable or
// whitespace byte from the start of that match on appears on the result channel,
// eight bytes behind the input. While a packet streams, one byte is accepted every
// cycle unless the result side stalls. After the last byte of a packet the eight-cell
// window drains through the output register: the item channel stalls while the cells
// that still hold bytes shift out, then for the closing word that carries is_http.
`default_nettype none
module http_signature_byte_filter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire sbf_pkg::sbf_in_t  item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output sbf_pkg::sbf_out_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [15:0]       cfg_data
);
	import sbf_pkg::*;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t      state_q;
	logic [15:0] http_port_q;
	logic        req_en_q;
	logic        rsp_en_q;
	logic        match_found_q;
	logic        verdict_q;
	logic        result_valid_q;
	sbf_out_t    result_q;

	logic        can_load;
	logic        accept;
	logic        drain_step;
	logic        any_valid;
	logic        shift;
	logic        kill;
	logic        req_en;
	logic        rsp_en;
	logic        match_eff;
	logic        match_new;
	logic        any_match;
	logic        emit_text;
	logic        closing;
	cell_t       head;

	logic [NUM_PATTERNS-1:0]      pat_en;
	logic [NUM_PATTERNS-1:0]      match;
	logic [NUM_PATTERNS-1:0]      hit_all;
	cell_t                        cell_in  [WINDOW_DEPTH];
	cell_t                        cell_out [WINDOW_DEPTH];
	logic [NUM_PATTERNS-1:0]      hit      [WINDOW_DEPTH];
	logic [NUM_PATTERNS-1:0][7:0] pat_bytes [WINDOW_DEPTH];
	logic [NUM_PATTERNS-1:0]      pat_used [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]      reach;
	logic [WINDOW_DEPTH-1:0]      valid_vec;

	assign cfg_ready = 1'b1;

	assign can_load   = ~result_valid_q | ~result_stall;
	assign item_stall = (state_q != ST_RUN) | ~can_load;
	assign accept     = item_valid & ~item_stall;
	assign drain_step = (state_q == ST_DRAIN) & can_load;
	assign kill       = accept & item.first_of_packet;

	assign req_en    = item.first_of_packet ? (item.dest_port == http_port_q) : req_en_q;
	assign rsp_en    = item.first_of_packet ? (item.source_port == http_port_q) : rsp_en_q;
	assign match_eff = match_found_q & ~item.first_of_packet;

	// Cell 0 holds the newest earlier byte, cell WINDOW_DEPTH-1 the oldest.
	genvar gi, gp;
	generate
		for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
			for (gp = 0; gp < NUM_PATTERNS; gp++) begin : g_pat
				assign pat_bytes[gi][gp] = PAT_STR[gp][8*(gi+1) +: 8];
				assign pat_used[gi][gp]  = (PAT_LEN[gp] > (gi + 1));
			end

			if (gi == 0) begin : g_head
				assign cell_in[gi] = head;
			end else begin : g_link
				assign cell_in[gi] = cell_out[gi-1];
			end

			assign reach[gi]     = accept & |(match & pat_used[gi]);
			assign valid_vec[gi] = cell_out[gi].valid;

			sbf_cell u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.shift         (shift),
				.kill          (kill),
				.mark_set      (reach[gi]),
				.load          (cell_in[gi]),
				.pattern_bytes (pat_bytes[gi]),
				.pattern_used  (pat_used[gi]),
				.slot          (cell_out[gi]),
				.hit           (hit[gi])
			);
		end
	endgenerate

	always_comb begin
		hit_all = '1;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			hit_all = hit_all & hit[i];
		end
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			pat_en[p] = (p == RESP_PATTERN) ? rsp_en : req_en;
			match[p]  = pat_en[p] & hit_all[p] & (item.data_byte == PAT_STR[p][7:0]);
		end
	end

	assign any_match = |match;
	assign match_new = match_eff | any_match;

	// While draining, empty words are shifted in behind the packet's last byte.
	always_comb begin
		if (accept) begin
			head.valid = 1'b1;
			head.mark  = match_new;
			head.data  = item.data_byte;
		end else begin
			head = '0;
		end
	end

	assign any_valid = |valid_vec;
	assign shift     = accept | (drain_step & any_valid);
	assign emit_text = shift & cell_out[WINDOW_DEPTH-1].valid & cell_out[WINDOW_DEPTH-1].mark &
		is_text(cell_out[WINDOW_DEPTH-1].data);
	assign closing   = drain_step & ~any_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RUN;
			http_port_q    <= HTTP_PORT_RESET;
			req_en_q       <= 1'b0;
			rsp_en_q       <= 1'b0;
			match_found_q  <= 1'b0;
			verdict_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				http_port_q <= cfg_data;
			end
			if (accept) begin
				req_en_q      <= req_en;
				rsp_en_q      <= rsp_en;
				match_found_q <= match_new & ~item.last_of_packet;
				if (item.last_of_packet) begin
					verdict_q <= match_new;
				end
			end
			case (state_q)
				ST_RUN: begin
					if (accept && item.last_of_packet) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (closing) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
			if (can_load) begin
				result_valid_q <= emit_text | closing;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (closing) begin
				result_q.text_byte     <= '0;
				result_q.end_of_packet <= 1'b1;
				result_q.is_http       <= verdict_q;
			end else begin
				result_q.text_byte     <= cell_out[WINDOW_DEPTH-1].data[6:0];
				result_q.end_of_packet <= 1'b0;
				result_q.is_http       <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- rtl/core/sbf_checker.sv -----
`default_nettype none
module sbf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire sbf_pkg::sbf_in_t  item,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire sbf_pkg::sbf_out_t result
);
	import sbf_pkg::*;

	logic [7:0] text_wide;

	assign text_wide = {1'b0, result.text_byte};

	// The closing word carries no text.
	a_close_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.end_of_packet) |-> (result.text_byte == 7'd0))
		else $error("closing word carries a text byte");

	// The verdict only appears on the closing word.
	a_verdict_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.end_of_packet) |-> !result.is_http)
		else $error("is_http set on a text word");

	// Only printable or whitespace bytes are released.
	a_text_printable: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.end_of_packet) |->
		(((text_wide >= 8'h09) && (text_wide <= 8'h0D)) ||
		 ((text_wide >= 8'h20) && (text_wide <= 8'h7E))))
		else $error("non-text byte released");

	// The window drains after a packet's last byte before more input is taken.
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.last_of_packet) |=> item_stall)
		else $error("input accepted right after the end of a packet");

	// A stalled result word holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result word changed");

endmodule

bind http_signature_byte_filter sbf_checker u_sbf_checker (.*);
`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sbf_pkg::sbf_in_t;
	import sbf_pkg::sbf_out_t;

	localparam int unsigned WINDOW = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned PHASE_WORDS = 82;
	localparam logic [15:0] DEFAULT_PORT = 16'd80;

	typedef enum int unsigned {
		SIG_GET, SIG_HEAD, SIG_POST, SIG_PUT, SIG_OPTION, SIG_HTTP11, SIG_COUNT
	} signature_e;

	// Right-justified: the last character of each signature sits in bits [7:0].
	localparam logic [71:0] SIGNATURE [SIG_COUNT] = '{
		72'("GET "), 72'("HEAD "), 72'("POST "), 72'("PUT "), 72'("OPTION "), 72'("HTTP/1.1 ")
	};
	localparam int unsigned SIG_LEN [SIG_COUNT] = '{4, 5, 5, 4, 7, 9};

	typedef struct {
		logic [7:0]  data;
		logic [15:0] src;
		logic [15:0] dst;
		bit          first;
		bit          last;
		bit          typed;
		logic [79:0] text;
		int unsigned text_len;
		bit          verdict;
	} plan_row_t;

	// Rows marked typed carry their own expectation: the text words in order, then the
	// closing word with the verdict when the row ends a packet. Other rows use the model.
	plan_row_t plan [25] = '{
		// No packet has been opened since reset, so neither port enable is set.
		'{8'h47, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h45, 16'd0,    16'd0,    1'b0, 1'b1, 1'b1, 80'd0,         0, 1'b0},
		// A packet of one byte gives only its closing word.
		'{8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 80'd0,         0, 1'b0},
		'{8'h00, 16'd0,    16'd80,   1'b1, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h47, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h45, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h54, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h20, 16'd0,    16'd0,    1'b0, 1'b1, 1'b1, 80'("GET "),   4, 1'b1},
		// Both ports on the HTTP port, and a restart before the first packet closes.
		'{8'h48, 16'd80,   16'd80,   1'b1, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h48, 16'd80,   16'd80,   1'b1, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h54, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h54, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h50, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h2F, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h31, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h2E, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h31, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h20, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h7F, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h0D, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0, 80'd0,         0, 1'b0},
		'{8'h78, 16'd0,    16'd0,    1'b0, 1'b1, 1'b0, 80'd0,         0, 1'b0},
		// Bytes after a closing word without a new first byte keep the old enables.
		'{8'h50, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h55, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h54, 16'd0,    16'd0,    1'b0, 1'b0, 1'b1, 80'd0,         0, 1'b0},
		'{8'h20, 16'd0,    16'd0,    1'b0, 1'b1, 1'b1, 80'("PUT "),   4, 1'b1}
	};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	sbf_in_t     item;
	logic        result_valid;
	logic        result_stall = 1'b0;
	sbf_out_t    result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Model state of the filter.
	logic [7:0]  held_byte [WINDOW];
	logic        held_mark [WINDOW];
	int unsigned held_count;
	logic        pkt_matched;
	logic        request_on;
	logic        response_on;
	logic [15:0] filter_port;

	sbf_out_t    step_words [$];
	sbf_out_t    text_expected [$];
	plan_row_t   pending_rows [$];

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	bit          stream_closed = 1'b1;
	logic [15:0] cur_port = DEFAULT_PORT;
	int unsigned stall_mode = 0;
	int unsigned stall_mode_left = 0;

	http_signature_byte_filter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit printable(input logic [7:0] b);
		return (b >= 8'h09 && b <= 8'h0D) || (b >= 8'h20 && b <= 8'h7E);
	endfunction

	function automatic sbf_out_t text_word(input logic [7:0] b);
		return '{text_byte: b[6:0], end_of_packet: 1'b0, is_http: 1'b0};
	endfunction

	function automatic void clear_window();
		for (int k = 0; k < WINDOW; k++) begin
			held_byte[k] = 8'h00;
			held_mark[k] = 1'b0;
		end
		held_count = 0;
		pkt_matched = 1'b0;
	endfunction

	// Works out the words that one accepted byte releases, into step_words.
	task automatic filter_step(input sbf_in_t w);
		logic [7:0]  seq [WINDOW + 1];
		logic        mark [WINDOW + 1];
		int unsigned n, best, s;
		bit          hit, enabled;
		step_words.delete();
		if (w.first_of_packet) begin
			clear_window();
			request_on = (w.dest_port == filter_port);
			response_on = (w.source_port == filter_port);
		end
		n = held_count;
		for (int k = 0; k < n; k++) begin
			seq[k] = held_byte[k];
			mark[k] = held_mark[k];
		end
		seq[n] = w.data_byte;
		mark[n] = pkt_matched;
		n++;
		// Of the signatures that end on this byte, the one starting earliest wins.
		best = n;
		for (int p = 0; p < SIG_COUNT; p++) begin
			enabled = (p == SIG_HTTP11) ? response_on : request_on;
			if (enabled && SIG_LEN[p] <= n) begin
				s = n - SIG_LEN[p];
				hit = 1'b1;
				for (int k = 0; k < SIG_LEN[p]; k++)
					if (seq[s + k] != SIGNATURE[p][8 * (SIG_LEN[p] - 1 - k) +: 8])
						hit = 1'b0;
				if (hit && s < best)
					best = s;
			end
		end
		if (best < n) begin
			for (int k = best; k < n; k++)
				mark[k] = 1'b1;
			pkt_matched = 1'b1;
		end
		if (w.last_of_packet) begin
			for (int k = 0; k < n; k++)
				if (mark[k] && printable(seq[k]))
					step_words.push_back(text_word(seq[k]));
			step_words.push_back('{text_byte: 7'd0, end_of_packet: 1'b1, is_http: pkt_matched});
			clear_window();
		end else if (n > WINDOW) begin
			if (mark[0] && printable(seq[0]))
				step_words.push_back(text_word(seq[0]));
			for (int k = 0; k < WINDOW; k++) begin
				held_byte[k] = seq[k + 1];
				held_mark[k] = mark[k + 1];
			end
			held_count = WINDOW;
		end else begin
			for (int k = 0; k < n; k++) begin
				held_byte[k] = seq[k];
				held_mark[k] = mark[k];
			end
			held_count = n;
		end
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		plan_row_t   row;
		sbf_out_t    want;
		logic [7:0]  ch;
		bit          typed;
		if (arst_n === 1'b1) begin
			if (cfg_valid && cfg_ready)
				filter_port = cfg_data;
			if (item_valid && !item_stall) begin
				typed = 1'b0;
				filter_step(item);
				if (pending_rows.size() != 0) begin
					row = pending_rows.pop_front();
					typed = row.typed;
				end
				if (typed) begin
					for (int unsigned k = 0; k < row.text_len; k++) begin
						ch = row.text[8 * (row.text_len - 1 - k) +: 8];
						text_expected.push_back(text_word(ch));
					end
					if (row.last)
						text_expected.push_back('{text_byte: 7'd0, end_of_packet: 1'b1,
							is_http: row.verdict});
				end else begin
					foreach (step_words[i])
						text_expected.push_back(step_words[i]);
				end
			end
			if (result_valid && !result_stall) begin
				if (text_expected.size() == 0) begin
					$error("word with nothing expected: text_byte %0h end_of_packet %0b is_http %0b",
						result.text_byte, result.end_of_packet, result.is_http);
					errors++;
				end else begin
					want = text_expected.pop_front();
					check_field("text_byte", 16'(want.text_byte), 16'(result.text_byte));
					check_field("end_of_packet", 16'(want.end_of_packet),
						16'(result.end_of_packet));
					check_field("is_http", 16'(want.is_http), 16'(result.is_http));
				end
			end
		end
	end

	// The result side alternates between no stalls, light stalls and heavy stalls.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_mode_left = $urandom_range(20, 200);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] filler();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'($urandom_range(0, 255));
			3: return 8'($urandom_range(9, 13));
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	task automatic send_word(input sbf_in_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 120)
				: $urandom_range(1, 12);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		burst_left--;
		words_sent++;
		stream_closed = w.last_of_packet;
	endtask

	// Holds the sender back until every expected word has come and the block is quiet.
	task automatic drain();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (text_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_port(input logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_port = value;
	endtask

	// Mostly packets that carry a signature in random surroundings; the rest are
	// broken signatures, continuations without a first byte, restarts and noise.
	task automatic random_packet();
		logic [7:0]  body [$];
		logic [15:0] sp, dp;
		int unsigned kind, sig, len, cut, pos;
		sbf_in_t     w;
		kind = $urandom_range(0, 9);
		sp = 16'($urandom_range(0, 65535));
		dp = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 4))
			1: dp = cur_port;
			2: sp = cur_port;
			3: begin
				sp = cur_port;
				dp = cur_port;
			end
			default: ;
		endcase
		if (kind == 9) begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				body.push_back(8'($urandom_range(0, 255)));
		end else begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
			for (int i = 0; i < len; i++)
				body.push_back(filler());
			if (kind <= 6) begin
				sig = $urandom_range(0, SIG_COUNT - 1);
				for (int i = 0; i < SIG_LEN[sig]; i++)
					body.push_back(SIGNATURE[sig][8 * (SIG_LEN[sig] - 1 - i) +: 8]);
				if (kind == 6) begin
					pos = body.size() - 1 - $urandom_range(0, SIG_LEN[sig] - 1);
					body[pos] = filler();
				end
			end
			len = $urandom_range(0, 14);
			for (int i = 0; i < len; i++)
				body.push_back(filler());
			if (body.size() == 0)
				body.push_back(filler());
		end
		cut = (kind == 8) ? $urandom_range(1, body.size()) : body.size();
		for (int i = 0; i < body.size(); i++) begin
			w.data_byte = body[i];
			w.source_port = sp;
			w.dest_port = dp;
			w.first_of_packet = (i == 0 && kind != 7) || i == cut;
			w.last_of_packet = (i == body.size() - 1);
			if (kind == 9) begin
				w.source_port = 16'($urandom_range(0, 65535));
				w.dest_port = 16'($urandom_range(0, 65535));
				w.first_of_packet = ($urandom_range(0, 9) == 0);
				w.last_of_packet = ($urandom_range(0, 9) == 0);
			end
			send_word(w);
		end
	endtask

	initial begin
		sbf_in_t     w;
		logic [15:0] port_plan [5];
		int unsigned phase_end;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		filter_port = DEFAULT_PORT;
		request_on = 1'b0;
		response_on = 1'b0;
		clear_window();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			w = '{data_byte: plan[i].data, source_port: plan[i].src, dest_port: plan[i].dst,
				first_of_packet: plan[i].first, last_of_packet: plan[i].last};
			pending_rows.push_back(plan[i]);
			send_word(w);
		end
		drain();

		port_plan = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), DEFAULT_PORT, 16'd8080};
		foreach (port_plan[ph]) begin
			write_port(port_plan[ph]);
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				random_packet();
				if ($urandom_range(0, 11) == 0)
					drain();
			end
			// The block is only idle once the open packet has been closed.
			if (!stream_closed) begin
				w = '{data_byte: filler(), source_port: 16'($urandom_range(0, 65535)),
					dest_port: 16'($urandom_range(0, 65535)), first_of_packet: 1'b0,
					last_of_packet: 1'b1};
				send_word(w);
			end
			drain();
		end

		if (errors == 0 && text_expected.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
